FILE: design/dcrc_pkg.sv
package dcrc_pkg;

  localparam int GRID_COLUMNS = 32;
  localparam int GRID_ROWS    = 24;

  // fixed port field widths
  localparam int CELL_COL_W = 5;
  localparam int CELL_ROW_W = 5;
  localparam int RECT_WID_W = 6;
  localparam int RECT_HGT_W = 5;

  // internal widths follow the grid size
  localparam int COL_AW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int ROW_AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int WID_W  = $clog2(GRID_COLUMNS + 1);
  localparam int HGT_W  = $clog2(GRID_ROWS + 1);

  localparam logic OP_MARK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_IN_ROW,
    PTR_ZERO,
    PTR_INC,
    PTR_TOP
  } ptr_op_e;

  typedef struct packed {
    logic    cap;
    ptr_op_e ptr_op;
    logic    mark_wr;
    logic    clr_wr;
    logic    scan_hit;
    logic    grow;
    logic    single;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic rd_nz;
    logic rd_bit;
    logic ptr_last;
    logic clr_last;
  } sts_t;

endpackage

FILE: design/dcrc_in_if.sv
interface dcrc_in_if import dcrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [CELL_COL_W-1:0] cell_column;
  logic [CELL_ROW_W-1:0] cell_row;

  modport source (output valid, output opcode, output cell_column, output cell_row,
                  input ready);
  modport sink (input valid, input opcode, input cell_column, input cell_row,
                output ready);
endinterface

FILE: design/dcrc_out_if.sv
interface dcrc_out_if import dcrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [CELL_COL_W-1:0] rect_column;
  logic [CELL_ROW_W-1:0] rect_row;
  logic [RECT_WID_W-1:0] rect_width;
  logic [RECT_HGT_W-1:0] rect_height;

  modport source (output valid, output found, output rect_column, output rect_row,
                  output rect_width, output rect_height, input ready);
  modport sink (input valid, input found, input rect_column, input rect_row,
                input rect_width, input rect_height, output ready);
endinterface

FILE: design/dcrc_ctrl.sv
module dcrc_ctrl import dcrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  input  logic in_opcode_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MK_RD = 4'd1;
  localparam logic [3:0] ST_MK_WR = 4'd2;
  localparam logic [3:0] ST_SC_RD = 4'd3;
  localparam logic [3:0] ST_SC_EV = 4'd4;
  localparam logic [3:0] ST_GR_RD = 4'd5;
  localparam logic [3:0] ST_GR_EV = 4'd6;
  localparam logic [3:0] ST_CL_RD = 4'd7;
  localparam logic [3:0] ST_CL_WR = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       single_q;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.ptr_op = PTR_HOLD;
    cmd_o.single = single_q;
    in_ready_o  = (state_q == ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          if (in_opcode_i == OP_REQUEST) begin
            cmd_o.ptr_op = PTR_ZERO;
            state_d      = ST_SC_RD;
          end else begin
            cmd_o.ptr_op = PTR_IN_ROW;
            if (sts_i.in_ok) begin
              state_d = ST_MK_RD;
            end
          end
        end
      end
      ST_MK_RD: state_d = ST_MK_WR;
      ST_MK_WR: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_SC_RD: state_d = ST_SC_EV;
      ST_SC_EV: begin
        if (sts_i.rd_nz) begin
          cmd_o.scan_hit = 1'b1;
          if (single_q || sts_i.ptr_last) begin
            state_d = ST_CL_RD;
          end else begin
            cmd_o.ptr_op = PTR_INC;
            state_d      = ST_GR_RD;
          end
        end else if (sts_i.ptr_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = ST_SC_RD;
        end
      end
      ST_GR_RD: state_d = ST_GR_EV;
      ST_GR_EV: begin
        if (sts_i.rd_bit) begin
          cmd_o.grow = 1'b1;
          if (sts_i.ptr_last) begin
            cmd_o.ptr_op = PTR_TOP;
            state_d      = ST_CL_RD;
          end else begin
            cmd_o.ptr_op = PTR_INC;
            state_d      = ST_GR_RD;
          end
        end else begin
          cmd_o.ptr_op = PTR_TOP;
          state_d      = ST_CL_RD;
        end
      end
      ST_CL_RD: state_d = ST_CL_WR;
      ST_CL_WR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = ST_CL_RD;
        end
      end
      ST_DONE: begin
        // result register free or being drained this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      single_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        single_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/dcrc_datapath.sv
module dcrc_datapath import dcrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [CELL_COL_W-1:0] cell_column_i,
  input  logic [CELL_ROW_W-1:0] cell_row_i,
  output logic                  found_o,
  output logic [CELL_COL_W-1:0] rect_column_o,
  output logic [CELL_ROW_W-1:0] rect_row_o,
  output logic [RECT_WID_W-1:0] rect_width_o,
  output logic [RECT_HGT_W-1:0] rect_height_o
);

  localparam int SUM_W = HGT_W + 1;

  // one word per grid row, bit i is column i
  logic [GRID_COLUMNS-1:0] mem_q [GRID_ROWS];
  logic [GRID_ROWS-1:0]    row_vld_q;
  logic [GRID_COLUMNS-1:0] rd_raw_q;
  logic                    rd_vld_q;
  logic [GRID_COLUMNS-1:0] rdata;

  logic [COL_AW-1:0] col_in_q;
  logic [ROW_AW-1:0] ptr_q, ptr_d;
  logic [ROW_AW-1:0] r_q;
  logic [COL_AW-1:0] c_q;
  logic [WID_W-1:0]  w_q;
  logic [HGT_W-1:0]  h_q;
  logic              found_q;

  logic [COL_AW-1:0]       first_col;
  logic [WID_W-1:0]        run_first;
  logic [WID_W-1:0]        run_c;
  logic [GRID_COLUMNS-1:0] clr_mask;
  logic [GRID_COLUMNS-1:0] set_bit;
  logic [GRID_COLUMNS-1:0] wdata;
  logic                    wr_en;

  logic                  found_oq;
  logic [CELL_COL_W-1:0] rect_column_q;
  logic [CELL_ROW_W-1:0] rect_row_q;
  logic [RECT_WID_W-1:0] rect_width_q;
  logic [RECT_HGT_W-1:0] rect_height_q;

  // trailing ones count
  function automatic logic [WID_W-1:0] run_len(logic [GRID_COLUMNS-1:0] v);
    logic [WID_W-1:0] n;
    n = WID_W'(GRID_COLUMNS);
    for (int i = GRID_COLUMNS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        n = WID_W'(i);
      end
    end
    return n;
  endfunction

  always_comb begin
    first_col = '0;
    for (int i = GRID_COLUMNS - 1; i >= 0; i--) begin
      if (rdata[i]) begin
        first_col = COL_AW'(i);
      end
    end
  end

  assign rdata     = rd_vld_q ? rd_raw_q : '0;
  assign run_first = run_len(rdata >> first_col);
  assign run_c     = run_len(rdata >> c_q);

  always_comb begin
    for (int i = 0; i < GRID_COLUMNS; i++) begin
      clr_mask[i] = (i >= int'(c_q)) && (i < int'(c_q) + int'(w_q));
      set_bit[i]  = (i == int'(col_in_q));
    end
  end

  assign wr_en = cmd_i.mark_wr | cmd_i.clr_wr;
  assign wdata = cmd_i.mark_wr ? (rdata | set_bit) : (rdata & ~clr_mask);

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      PTR_HOLD:   ptr_d = ptr_q;
      PTR_IN_ROW: ptr_d = ROW_AW'(cell_row_i);
      PTR_ZERO:   ptr_d = '0;
      PTR_INC:    ptr_d = ptr_q + ROW_AW'(1);
      PTR_TOP:    ptr_d = r_q;
      default:    ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ptr_q] <= wdata;
    end
    rd_raw_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      ptr_q     <= '0;
      found_q   <= 1'b0;
      found_oq  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[ptr_q] <= 1'b1;
      end
      rd_vld_q <= row_vld_q[ptr_q];
      ptr_q    <= ptr_d;
      if (cmd_i.cap) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        found_oq <= found_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      col_in_q <= COL_AW'(cell_column_i);
    end
    if (cmd_i.scan_hit) begin
      r_q <= ptr_q;
      c_q <= first_col;
      w_q <= cmd_i.single ? WID_W'(1) : run_first;
      h_q <= HGT_W'(1);
    end else if (cmd_i.grow) begin
      h_q <= h_q + HGT_W'(1);
      if (run_c < w_q) begin
        w_q <= run_c;
      end
    end
    if (cmd_i.out_load) begin
      rect_column_q <= found_q ? CELL_COL_W'(c_q) : '0;
      rect_row_q    <= found_q ? CELL_ROW_W'(r_q) : '0;
      rect_width_q  <= found_q ? RECT_WID_W'(w_q) : '0;
      rect_height_q <= found_q ? RECT_HGT_W'(h_q) : '0;
    end
  end

  assign sts_o.in_ok    = (int'(cell_column_i) < GRID_COLUMNS) &&
                          (int'(cell_row_i) < GRID_ROWS);
  assign sts_o.rd_nz    = |rdata;
  assign sts_o.rd_bit   = rdata[c_q];
  assign sts_o.ptr_last = (ptr_q == ROW_AW'(GRID_ROWS - 1));
  assign sts_o.clr_last = (SUM_W'(ptr_q) + SUM_W'(1)) == (SUM_W'(r_q) + SUM_W'(h_q));

  assign found_o       = found_oq;
  assign rect_column_o = rect_column_q;
  assign rect_row_o    = rect_row_q;
  assign rect_width_o  = rect_width_q;
  assign rect_height_o = rect_height_q;

endmodule

FILE: design/dirty_cell_rectangle_coalescer_core.sv
// channel   dir  payload                                           handshake
// in_i      in   opcode, cell_column, cell_row                     valid/ready
// out_o     out  found, rect_column, rect_row, rect_width, height  valid/ready
// cfg       in   single_cell_mode                                  cfg_we_i, no wait
//
// Mark beat: accept, row read, row write; a mark off the grid is only accepted.
// Request beat: a read and an evaluate step per row scanned through the first marked
// row (all rows when none), a read and an evaluate step per row probed below it in
// merge mode, a read and a write step per rectangle row cleared, then a step to load
// the result; one single-port row memory, read and written once per step, sets this.
// Reset clears the per-row valid flops, so the map reads all zero at once.
// A pending result stalls only the final load step; until a request reaches it, marks keep being accepted.
module dirty_cell_rectangle_coalescer_core import dcrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  dcrc_in_if.sink     in_i,
  dcrc_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  dcrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dcrc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cell_column_i (in_i.cell_column),
    .cell_row_i    (in_i.cell_row),
    .found_o       (out_o.found),
    .rect_column_o (out_o.rect_column),
    .rect_row_o    (out_o.rect_row),
    .rect_width_o  (out_o.rect_width),
    .rect_height_o (out_o.rect_height)
  );

endmodule

FILE: verif/tb_dirty_cell_rectangle_coalescer_core.sv
import dcrc_pkg::*;

typedef struct packed {
  logic                  found;
  logic [CELL_COL_W-1:0] column;
  logic [CELL_ROW_W-1:0] row;
  logic [RECT_WID_W-1:0] width;
  logic [RECT_HGT_W-1:0] height;
} rect_t;

class rect_scoreboard;
  bit    dirty [GRID_ROWS][GRID_COLUMNS];
  bit    single_mode;
  rect_t rect_q[$];
  int    errors;

  // pops the next dirty rectangle off the local map
  function rect_t take_rect();
    rect_t r;
    int    top;
    int    left;
    int    w;
    int    h;
    bit    full;
    r    = '0;
    top  = -1;
    left = 0;
    for (int y = 0; y < GRID_ROWS && top < 0; y++)
      for (int x = 0; x < GRID_COLUMNS && top < 0; x++)
        if (dirty[y][x]) begin
          top  = y;
          left = x;
        end
    if (top < 0) return r;
    dirty[top][left] = 1'b0;
    w = 1;
    h = 1;
    if (!single_mode) begin
      while (top + h < GRID_ROWS && dirty[top + h][left]) begin
        dirty[top + h][left] = 1'b0;
        h++;
      end
      // a partly marked column is left untouched and ends growth
      full = 1'b1;
      while (left + w < GRID_COLUMNS && full) begin
        for (int y = top; y < top + h; y++) full &= dirty[y][left + w];
        if (full) begin
          for (int y = top; y < top + h; y++) dirty[y][left + w] = 1'b0;
          w++;
        end
      end
    end
    r.found  = 1'b1;
    r.column = CELL_COL_W'(left);
    r.row    = CELL_ROW_W'(top);
    r.width  = RECT_WID_W'(w);
    r.height = RECT_HGT_W'(h);
    return r;
  endfunction

  function void note_input(logic op, logic [CELL_COL_W-1:0] col, logic [CELL_ROW_W-1:0] row);
    if (op == OP_MARK) begin
      if (col < GRID_COLUMNS && row < GRID_ROWS) dirty[row][col] = 1'b1;
    end else begin
      rect_q.push_back(take_rect());
    end
  endfunction

  function void cmp(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(rect_t got);
    rect_t want;
    if (rect_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual found=%0d col=%0d row=%0d w=%0d h=%0d",
               $time, got.found, got.column, got.row, got.width, got.height);
      errors++;
      return;
    end
    want = rect_q.pop_front();
    cmp("found", int'(want.found), int'(got.found));
    cmp("rect_column", int'(want.column), int'(got.column));
    cmp("rect_row", int'(want.row), int'(got.row));
    cmp("rect_width", int'(want.width), int'(got.width));
    cmp("rect_height", int'(want.height), int'(got.height));
  endfunction
endclass

module tb_dirty_cell_rectangle_coalescer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 31;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 160;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_wdata_i;
  bit   no_idle;
  int   in_beats;
  rect_scoreboard sb;

  dcrc_in_if  in_if ();
  dcrc_out_if out_if ();

  dirty_cell_rectangle_coalescer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rect_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.opcode, in_if.cell_column, in_if.cell_row);
        in_beats++;
      end
      if (out_if.valid && out_if.ready) begin
        got.found  = out_if.found;
        got.column = out_if.rect_column;
        got.row    = out_if.rect_row;
        got.width  = out_if.rect_width;
        got.height = out_if.rect_height;
        sb.check_result(got);
      end
    end
  end

  // result sink, with one long hold-off to back up the input side
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && in_beats >= HOLD_AFTER) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall = 0;
      else stall++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(input logic op, input logic [CELL_COL_W-1:0] col,
                           input logic [CELL_ROW_W-1:0] row);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.cell_column <= col;
    in_if.cell_row    <= row;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_request();
    send_item(OP_REQUEST, CELL_COL_W'($urandom_range(31)), CELL_ROW_W'($urandom_range(31)));
  endtask

  // drop valid and let every outstanding result and mark finish
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.rect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    cfg_wdata_i <= mode;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    sb.single_mode  = mode;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int quota);
    int sent;
    int pick;
    int c0;
    int r0;
    int w;
    int h;
    int n;
    int r;
    bit holes;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        c0 = $urandom_range(GRID_COLUMNS - 1);
        r0 = $urandom_range(GRID_ROWS - 1);
        w  = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
        h  = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
        if (pick < 3) begin
          // full-width strip
          c0 = 0;
          w  = GRID_COLUMNS;
          h  = $urandom_range(1, 2);
        end else if (pick < 6) begin
          // full-height column
          r0 = 0;
          h  = GRID_ROWS;
          w  = 1;
        end
        if (c0 + w > GRID_COLUMNS) w = GRID_COLUMNS - c0;
        if (r0 + h > GRID_ROWS) h = GRID_ROWS - r0;
        holes = (pick >= 6 && pick < 35);
        for (int y = r0; y < r0 + h; y++)
          for (int x = c0; x < c0 + w; x++)
            if (!holes || $urandom_range(9) != 0) begin
              send_item(OP_MARK, CELL_COL_W'(x), CELL_ROW_W'(y));
              sent++;
            end
        n = $urandom_range(1, 3);
        repeat (n) begin
          send_request();
          sent++;
        end
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          r = $urandom_range(31);
          send_item(OP_MARK, CELL_COL_W'($urandom_range(31)), CELL_ROW_W'(r));
          sent++;
        end
      end else begin
        send_request();
        sent++;
      end
      if ($urandom_range(99) < 3) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    in_if.valid       <= 1'b0;
    in_if.opcode      <= OP_MARK;
    in_if.cell_column <= '0;
    in_if.cell_row    <= '0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);

    // empty map
    send_item(OP_REQUEST, 5'd31, 5'd31);
    // 2x2 block in the corner
    send_item(OP_MARK, 5'd0, 5'd0);
    send_item(OP_MARK, 5'd1, 5'd0);
    send_item(OP_MARK, 5'd0, 5'd1);
    send_item(OP_MARK, 5'd1, 5'd1);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    // column to the right marked only in its top row
    send_item(OP_MARK, 5'd5, 5'd3);
    send_item(OP_MARK, 5'd5, 5'd4);
    send_item(OP_MARK, 5'd6, 5'd3);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    // marks off the grid leave the map empty
    send_item(OP_MARK, 5'd31, 5'd24);
    send_item(OP_MARK, 5'd0, 5'd31);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    // far corner, marked twice
    send_item(OP_MARK, 5'd31, 5'd23);
    send_item(OP_MARK, 5'd31, 5'd23);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    wait_drained();
    write_mode(1'b1);
    send_item(OP_MARK, 5'd2, 5'd2);
    send_item(OP_MARK, 5'd3, 5'd2);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    send_item(OP_REQUEST, 5'd0, 5'd0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_mode(p[0]);
      no_idle = (p == 2);
      random_phase(PHASE_ITEMS);
      wait_drained();
    end
    no_idle = 1'b0;
    repeat (20) @(posedge clk_i);

    if (sb.rect_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.rect_q.size());
    if (sb.errors == 0 && sb.rect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
